[src/bsep_pkg.sv]
// shared types and constants of the burning ship escape-time pixel engine
package bsep_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd2;

  localparam logic [8:0] ITER_CAP = 9'd256;

  // register stages of the plane mapping
  localparam int DIV_STEPS = 2;

  typedef struct packed {
    logic [7:0] pixel_col;
    logic [7:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [12:0] screen_x;
    logic [12:0] screen_y;
    logic [8:0]  iterations;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic c_load;
    logic iter_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic stop;
  } sts_t;

endpackage

[src/bsep_coord.sv]
// maps a tile coordinate to a saturated plane coordinate by reciprocal multiplication
module bsep_coord #(
  parameter int TILE_SIZE = 200,
  parameter int FRAC_BITS = 28,
  parameter int TW        = 8,
  parameter int DW        = 9
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [7:0]                pixel,
  output logic [FRAC_BITS+3:0]      c
);

  localparam int MW   = FRAC_BITS + 4;
  localparam int MGW  = DW - 1;
  localparam int NW   = MGW + 2;
  localparam int DVW  = NW + FRAC_BITS;
  localparam int VW   = NW + TW;
  localparam int SH   = VW + TW;
  localparam int RW   = NW + TW + 2;
  localparam int PW   = VW + RW;
  localparam int HALF = TILE_SIZE / 2;
  localparam logic [DW-1:0]  HALF_D = DW'(HALF);
  localparam logic [63:0]    P2F    = 64'd1 << FRAC_BITS;
  localparam logic [63:0]    P2S    = 64'd1 << SH;
  localparam logic [DVW-1:0] Q0_C   = DVW'(P2F / 64'(TILE_SIZE));
  localparam logic [VW-1:0]  R0_C   = VW'(P2F % 64'(TILE_SIZE));
  localparam logic [PW-1:0]  M_C    =
    PW'((P2S + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE));
  localparam logic [DVW-1:0] LIM    = DVW'(1) << (FRAC_BITS + 3);

  logic [DW-1:0]    d;
  logic [DW-1:0]    d_abs;
  logic [MGW-1:0]   mag;
  logic [NW-1:0]    num;
  logic [NW-1:0]    num_r;
  logic [DVW-1:0]   hi_r;
  logic [VW-1:0]    v_r;
  logic [PW-1:0]    prod;
  logic [DVW-1:0]   quo_r;
  logic             neg_r;
  logic [DVW-1:0]   sat_neg;
  logic [DVW-1:0]   sat_pos;
  logic [MW-1:0]    sn;

  assign d       = {{(DW-8){1'b0}}, pixel} - HALF_D;
  assign d_abs   = d[DW-1] ? (~d + 1'b1) : d;
  assign mag     = d_abs[MGW-1:0];
  assign num     = {2'b00, mag} + {1'b0, mag, 1'b0};

  // num * 2^frac / tile split into whole and remainder parts of 2^frac / tile
  assign prod    = PW'(v_r) * M_C;

  always_ff @(posedge clk) begin
    if (load) begin
      num_r <= num;
      neg_r <= d[DW-1];
    end else if (step) begin
      hi_r  <= DVW'(num_r) * Q0_C;
      v_r   <= VW'(num_r) * R0_C;
      quo_r <= hi_r + {{(DVW-PW+SH){1'b0}}, prod[PW-1:SH]};
    end
  end

  // clamp to the q4 range
  assign sat_neg = (quo_r > LIM) ? LIM : quo_r;
  assign sat_pos = (quo_r > (LIM - 1'b1)) ? (LIM - 1'b1) : quo_r;
  assign sn      = sat_neg[MW-1:0];
  assign c       = neg_r ? (~sn + 1'b1) : sat_pos[MW-1:0];

endmodule

[src/bsep_datapath.sv]
// datapath: config registers, plane mapping, iteration unit and result register
module bsep_datapath #(
  parameter int TILE_SIZE = 200,
  parameter int FRAC_BITS = 28,
  parameter int TW        = 8,
  parameter int DW        = 9
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsep_pkg::cmd_t                      cmd,
  output bsep_pkg::sts_t                      sts,
  input  bsep_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [bsep_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsep_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  output bsep_pkg::out_item_t                 out_data
);

  localparam int MW = FRAC_BITS + 4;
  localparam logic [MW+4:0] FOUR = (MW+5)'(4) << FRAC_BITS;

  logic [8:0]        max_iter_r;
  logic [11:0]       origin_x_r;
  logic [11:0]       origin_y_r;
  logic [7:0]        col_r;
  logic [7:0]        row_r;
  logic [MW-1:0]     cx_c;
  logic [MW-1:0]     cy_c;
  logic [MW-1:0]     cx_r;
  logic [MW-1:0]     cy_r;
  logic [MW-1:0]     x_r;
  logic [MW:0]       y_r;
  logic [8:0]        n_r;
  logic [8:0]        limit;
  logic [MW:0]       ay_full;
  logic [MW-1:0]     ay;
  logic [2*MW-1:0]   pxx;
  logic [2*MW-1:0]   pyy;
  logic [2*MW-1:0]   pxy;
  logic [MW+3:0]     xx;
  logic [MW+3:0]     yy;
  logic [MW+3:0]     xy;
  logic [MW+4:0]     rad;
  logic              esc;
  logic [MW+5:0]     nx;
  logic [MW+5:0]     nx_abs;
  logic [MW+5:0]     ny;
  logic [MW-1:0]     x_nxt;
  logic [MW:0]       y_nxt;
  logic              out_valid_r;
  bsep_pkg::out_item_t out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= bsep_pkg::ITER_CAP;
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bsep_pkg::CFG_MAX_ITER: max_iter_r <= cfg_wdata[8:0];
        bsep_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_wdata;
        bsep_pkg::CFG_ORIGIN_Y: origin_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign limit = (max_iter_r > bsep_pkg::ITER_CAP) ? bsep_pkg::ITER_CAP : max_iter_r;

  bsep_coord #(
    .TILE_SIZE(TILE_SIZE), .FRAC_BITS(FRAC_BITS), .TW(TW), .DW(DW)
  ) u_coord_x (
    .clk(clk), .load(cmd.load), .step(cmd.div_step),
    .pixel(in_data.pixel_col), .c(cx_c)
  );

  bsep_coord #(
    .TILE_SIZE(TILE_SIZE), .FRAC_BITS(FRAC_BITS), .TW(TW), .DW(DW)
  ) u_coord_y (
    .clk(clk), .load(cmd.load), .step(cmd.div_step),
    .pixel(in_data.pixel_row), .c(cy_c)
  );

  // one burning ship step per cycle while cmd.iter_step is high
  assign ay_full = y_r[MW] ? (~y_r + 1'b1) : y_r;
  assign ay      = ay_full[MW-1:0];
  assign pxx     = (2*MW)'(x_r) * (2*MW)'(x_r);
  assign pyy     = (2*MW)'(ay) * (2*MW)'(ay);
  assign pxy     = (2*MW)'(x_r) * (2*MW)'(ay);
  assign xx      = pxx[2*MW-1:FRAC_BITS];
  assign yy      = pyy[2*MW-1:FRAC_BITS];
  assign xy      = pxy[2*MW-1:FRAC_BITS];
  assign rad     = {1'b0, xx} + {1'b0, yy};
  assign esc     = (rad >= FOUR);
  assign nx      = {2'b00, xx} - {2'b00, yy} + {{6{cx_r[MW-1]}}, cx_r};
  assign nx_abs  = nx[MW+5] ? (~nx + 1'b1) : nx;
  assign x_nxt   = nx_abs[MW-1:0];
  assign ny      = {1'b0, xy, 1'b0} + {{6{cy_r[MW-1]}}, cy_r};
  assign y_nxt   = ny[MW:0];

  assign sts.stop = esc || (n_r == limit);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= in_data.pixel_col;
      row_r <= in_data.pixel_row;
    end
    if (cmd.c_load) begin
      cx_r <= cx_c;
      cy_r <= cy_c;
      x_r  <= '0;
      y_r  <= '0;
      n_r  <= '0;
    end else if (cmd.iter_step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      n_r <= n_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.screen_x   <= {1'b0, origin_x_r} + {5'b0, col_r};
      out_data_r.screen_y   <= {1'b0, origin_y_r} + {5'b0, row_r};
      out_data_r.iterations <= n_r;
      out_data_r.red        <= {n_r[4:0], 3'b000};
      out_data_r.green      <= {n_r[3:0], 4'b0000};
      out_data_r.blue       <= {n_r[2:0], 5'b00000};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/bsep_ctrl.sv]
// controller: sequences divide, setup and iteration phases of one item
module bsep_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output bsep_pkg::cmd_t cmd,
  input  bsep_pkg::sts_t sts
);

  localparam int CW = $clog2(bsep_pkg::DIV_STEPS + 1);
  localparam logic [CW-1:0] LAST = CW'(bsep_pkg::DIV_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SAT,
    S_ITER
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && start;
    cmd.div_step  = (state_r == S_DIV);
    cmd.c_load    = (state_r == S_SAT);
    cmd.iter_step = (state_r == S_ITER) && !sts.stop;
    cmd.finish    = (state_r == S_ITER) && sts.stop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DIV;
            cnt_r   <= '0;
            busy_r  <= 1'b1;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          state_r <= S_ITER;
        end
        S_ITER: begin
          if (sts.stop) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy = busy_r;

endmodule

[src/burning_ship_escape_time_pixel.sv]
// top level of the burning ship escape-time pixel engine
// sequence: the item is registered on acceptance, the plane mapping steps in S_DIV, the
// coordinates load in S_SAT, the step unit runs one iteration per cycle until stop
// and finish is registered into out_valid; the next item may start the cycle out_valid shows
// rst_n synchronous active low: idle, no result pending, max_iter 256, origins 0
module burning_ship_escape_time_pixel #(
  parameter int TILE_SIZE = 200,
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  bsep_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output bsep_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bsep_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsep_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int TW  = $clog2(TILE_SIZE + 1);
  localparam int DW  = (((TW - 1) > 8) ? (TW - 1) : 8) + 1;

  bsep_pkg::cmd_t cmd;
  bsep_pkg::sts_t sts;

  bsep_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  bsep_datapath #(
    .TILE_SIZE(TILE_SIZE), .FRAC_BITS(FRAC_BITS), .TW(TW), .DW(DW)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

[src/bsep_checker.sv]
// port-level checks of the pixel engine and their binding to the top level
module bsep_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input bsep_pkg::out_item_t out_data
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after item accepted");

  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red == {out_data.iterations[4:0], 3'b000}) &&
                  (out_data.green == {out_data.iterations[3:0], 4'b0000}) &&
                  (out_data.blue == {out_data.iterations[2:0], 5'b00000}))
    else $error("colour does not follow iteration count");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.iterations <= bsep_pkg::ITER_CAP)
    else $error("iteration count above cap");

endmodule

bind burning_ship_escape_time_pixel bsep_checker u_bsep_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);

[test/testbench.sv]
// self-checking testbench of the burning ship escape-time pixel engine
`timescale 1ns / 100ps

module testbench;

  localparam int TILE_SIZE = 200;
  localparam int FRAC_BITS = 28;
  localparam longint PLANE_LIM = longint'(8) << FRAC_BITS;
  localparam longint ESCAPE_RADIUS_SQ = longint'(4) << FRAC_BITS;
  localparam logic [bsep_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2_500_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  bsep_pkg::in_item_t in_data = '0;
  logic out_valid;
  bsep_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [bsep_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bsep_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bsep_pkg::in_item_t pixel_q[$];
  bsep_pkg::out_item_t escape_q[$];
  logic [8:0] iter_limit = bsep_pkg::ITER_CAP;
  logic [11:0] org_x = '0;
  logic [11:0] org_y = '0;
  logic no_idle = 1'b0;
  logic slot_free;
  int gap_left = 0;
  int errors = 0;
  int cycle_count = 0;

  burning_ship_escape_time_pixel dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return longint'(prod[FRAC_BITS +: 64]);
  endfunction

  function automatic longint plane_coord(logic [7:0] p);
    longint d;
    longint q;
    d = longint'(p);
    d = d - longint'(TILE_SIZE / 2);
    q = ((d < 0) ? -d : d) * longint'(3);
    q = (q << FRAC_BITS) / longint'(TILE_SIZE);
    if (d < 0) begin
      if (q > PLANE_LIM) q = PLANE_LIM;
      return -q;
    end
    if (q > PLANE_LIM - 1) q = PLANE_LIM - 1;
    return q;
  endfunction

  function automatic bsep_pkg::out_item_t escape_pixel(bsep_pkg::in_item_t px);
    bsep_pkg::out_item_t res;
    longint cx, cy, x, y, ax, ay, xx, yy, xy, nx;
    int limit;
    int n;
    cx = plane_coord(px.pixel_col);
    cy = plane_coord(px.pixel_row);
    x = 0;
    y = 0;
    n = 0;
    limit = (iter_limit > bsep_pkg::ITER_CAP) ? int'(bsep_pkg::ITER_CAP) : int'(iter_limit);
    while (n < limit) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      xx = fx_mul(ax, ax);
      yy = fx_mul(ay, ay);
      if (xx + yy >= ESCAPE_RADIUS_SQ) break;
      xy = fx_mul(ax, ay);
      nx = xx - yy + cx;
      y = longint'(2) * xy + cy;
      x = (nx < 0) ? -nx : nx;
      n++;
    end
    res.screen_x = 13'(org_x) + 13'(px.pixel_col);
    res.screen_y = 13'(org_y) + 13'(px.pixel_row);
    res.iterations = n[8:0];
    res.red = 8'((n % 32) * 8);
    res.green = 8'((n % 16) * 16);
    res.blue = 8'((n % 8) * 32);
    return res;
  endfunction

  // driver: one item at a time, random gap after each accepted item, none in no_idle phases
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else begin
      slot_free = !start || !busy;
      if (start && !busy) escape_q.push_back(escape_pixel(in_data));
      if (slot_free) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_data <= pixel_q.pop_front();
          start <= 1'b1;
          gap_left <= no_idle ? 0 : int'($urandom_range(0, 10));
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (escape_q.size() == 0) begin
        $error("result item with nothing expected: %p", out_data);
        errors++;
      end else begin
        bsep_pkg::out_item_t want;
        want = escape_q.pop_front();
        if (out_data.screen_x !== want.screen_x) begin
          $error("screen_x expected %0d actual %0d", want.screen_x, out_data.screen_x);
          errors++;
        end
        if (out_data.screen_y !== want.screen_y) begin
          $error("screen_y expected %0d actual %0d", want.screen_y, out_data.screen_y);
          errors++;
        end
        if (out_data.iterations !== want.iterations) begin
          $error("iterations expected %0d actual %0d", want.iterations, out_data.iterations);
          errors++;
        end
        if (out_data.red !== want.red) begin
          $error("red expected %0d actual %0d", want.red, out_data.red);
          errors++;
        end
        if (out_data.green !== want.green) begin
          $error("green expected %0d actual %0d", want.green, out_data.green);
          errors++;
        end
        if (out_data.blue !== want.blue) begin
          $error("blue expected %0d actual %0d", want.blue, out_data.blue);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || escape_q.size() != 0 || start || busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [bsep_pkg::CFG_IDX_W-1:0] idx,
                           logic [bsep_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bsep_pkg::CFG_MAX_ITER: iter_limit = val[8:0];
      bsep_pkg::CFG_ORIGIN_X: org_x = val;
      bsep_pkg::CFG_ORIGIN_Y: org_y = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_pixel(logic [7:0] col, logic [7:0] row);
    bsep_pkg::in_item_t px;
    px.pixel_col = col;
    px.pixel_row = row;
    pixel_q.push_back(px);
  endtask

  function automatic logic [11:0] pick_origin();
    case ($urandom_range(0, 3))
      0: return 12'd0;
      1: return 12'd4095;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 12'd1;
      1: return 12'd256;
      2: return 12'($urandom);
      3: return 12'($urandom_range(33, 255));
      4: return 12'd0;
      default: return 12'($urandom_range(1, 32));
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: full limit, origins at zero
    wait_idle();
    queue_pixel(8'd0, 8'd0);
    queue_pixel(8'd199, 8'd199);
    queue_pixel(8'd255, 8'd255);
    queue_pixel(8'd0, 8'd255);
    queue_pixel(8'd255, 8'd0);
    queue_pixel(8'd100, 8'd100);
    queue_pixel(8'd99, 8'd100);
    queue_pixel(8'd101, 8'd99);
    queue_pixel(8'd200, 8'd200);
    queue_pixel(8'd128, 8'd127);
    queue_pixel(8'd170, 8'd85);
    queue_pixel(8'd85, 8'd170);
    queue_pixel(8'd60, 8'd90);
    queue_pixel(8'd150, 8'd40);

    // zero limit, origins at the top, write to an unused index
    wait_idle();
    write_reg(bsep_pkg::CFG_MAX_ITER, 12'd0);
    write_reg(bsep_pkg::CFG_ORIGIN_X, 12'd4095);
    write_reg(bsep_pkg::CFG_ORIGIN_Y, 12'd4095);
    write_reg(CFG_UNUSED, 12'hFFF);
    end_writes();
    queue_pixel(8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0);
    queue_pixel(8'd100, 8'd100);
    queue_pixel(8'd199, 8'd0);
    queue_pixel(8'd0, 8'd199);
    queue_pixel(8'd240, 8'd15);

    // limit above the cap, upper data bits set
    wait_idle();
    write_reg(bsep_pkg::CFG_MAX_ITER, 12'hFFF);
    write_reg(bsep_pkg::CFG_ORIGIN_X, 12'd1234);
    write_reg(bsep_pkg::CFG_ORIGIN_Y, 12'd2345);
    end_writes();
    queue_pixel(8'd100, 8'd100);
    queue_pixel(8'd70, 8'd100);
    queue_pixel(8'd255, 8'd128);
    queue_pixel(8'd0, 8'd50);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_reg(bsep_pkg::CFG_MAX_ITER, pick_limit());
      write_reg(bsep_pkg::CFG_ORIGIN_X, pick_origin());
      write_reg(bsep_pkg::CFG_ORIGIN_Y, pick_origin());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 12'($urandom));
      end_writes();
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 99) < 85)
          queue_pixel(8'($urandom_range(0, 199)), 8'($urandom_range(0, 199)));
        else
          queue_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
